// ----- rtl/ptts_pkg.sv -----
// package: sequencer states and action codes of the tick scheduler
package ptts_pkg;

    // action codes carried on the slave-side tuser
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_CREATE   = 3'd1;
    localparam logic [2:0] ACT_WAKE     = 3'd2;
    localparam logic [2:0] ACT_SLEEP    = 3'd3;
    localparam logic [2:0] ACT_DISPATCH = 3'd4;

    localparam int ACTION_BITS = 3;
    localparam int TASK_ID_BITS = 4;
    localparam int IN_PERIOD_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_TICK_LAST,
        S_SCAN,
        S_DONE
    } sched_state_t;

endpackage

// ----- rtl/periodic_task_tick_scheduler_core.sv -----
// top level: periodic task tick scheduler with a shared per-slot update unit
//
// channel   dir  group         fields (lowest bit first)
// --------  ---  ------------  ------------------------------------------------
// request   in   s_axis_*      tuser: action[2:0]; tdata: task_id[3:0], period[19:4]
// result    out  m_axis_*      tuser: granted[0];  tdata: granted_task[3:0]
//
// sequence: a tick reads the slots in order, one slot per cycle from the period and
//   counter memories, with the writeback in the cycle after the read; a dispatch
//   examines one slot per cycle from the scan position; the rest go straight to done
// reset: rst_n clears the created and pending bits, the scan position and the
//   sequencer; the memories need no clearing since only created slots are written back
// stalls: a request is taken only when the sequencer is idle; a finished result
//   waits in the output register while the next request is taken
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS  = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // task_id[3:0], period[19:4], zero fill
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // granted_task[3:0], zero fill
    output logic [0:0]  m_axis_tuser    // granted[0]
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

    // request fields
    logic [ACTION_BITS-1:0]    in_action;
    logic [TASK_ID_BITS-1:0]   in_task_id;
    logic [IN_PERIOD_BITS-1:0] in_period;
    logic [31:0]               id_ext;
    logic                      id_ok;
    logic [SW-1:0]             id_slot;
    logic [31:0]               per_ext;
    logic                      in_accept;

    // control state
    sched_state_t            state_reg, state_next;
    logic [TASK_SLOTS-1:0]   created_reg, created_next;
    logic [TASK_SLOTS-1:0]   pending_reg, pending_next;
    logic [SW-1:0]           scan_pos_reg, scan_pos_next;
    logic [SW-1:0]           idx_reg, idx_next;      // tick read index / scan pointer
    logic [SW-1:0]           cnt_reg, cnt_next;      // slots examined by a scan
    logic                    wb_valid_reg, wb_valid_next;
    logic [SW-1:0]           wb_idx_reg, wb_idx_next;
    logic                    res_granted_reg, res_granted_next;
    logic [SW-1:0]           res_slot_reg, res_slot_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_granted_reg, out_granted_next;
    logic [3:0]              out_task_reg, out_task_next;

    // slot memories
    logic [PERIOD_BITS-1:0]  period_mem [TASK_SLOTS];
    logic [PERIOD_BITS-1:0]  elapsed_mem [TASK_SLOTS];
    logic [PERIOD_BITS-1:0]  period_rd_reg;
    logic [PERIOD_BITS-1:0]  elapsed_rd_reg;
    logic                    period_we;
    logic                    elapsed_we;
    logic [SW-1:0]           elapsed_waddr;
    logic [PERIOD_BITS-1:0]  elapsed_wdata;

    // shared update unit: one increment and compare per slot
    logic [PERIOD_BITS-1:0]  limit;
    logic [PERIOD_BITS-1:0]  count_inc;
    logic                    fire;
    logic                    wb_active;

    // scan helpers
    logic                    hit;
    logic [SW-1:0]           idx_inc;
    logic [31:0]             res_slot_ext;

    assign in_action  = s_axis_tuser;
    assign in_task_id = s_axis_tdata[3:0];
    assign in_period  = s_axis_tdata[19:4];
    assign id_ext     = 32'(in_task_id);
    assign id_ok      = id_ext < TASK_SLOTS;
    assign id_slot    = id_ext[SW-1:0];
    assign per_ext    = 32'(in_period);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // per-slot counter step, in the cycle after the memory read
    assign limit     = (period_rd_reg == '0) ? PERIOD_BITS'(1) : period_rd_reg;
    assign count_inc = elapsed_rd_reg + PERIOD_BITS'(1);
    assign fire      = (count_inc >= limit) || (count_inc == '0);
    assign wb_active = wb_valid_reg && created_reg[wb_idx_reg];

    // round-robin pointer step and slot test
    assign idx_inc = (idx_reg == LAST_SLOT) ? '0 : idx_reg + SW'(1);
    assign hit     = created_reg[idx_reg] && pending_reg[idx_reg];

    // memory write ports: create in idle, counter writeback during a tick
    assign period_we     = in_accept && (in_action == ACT_CREATE) && id_ok
                           && !created_reg[id_slot];
    assign elapsed_we    = period_we || wb_active;
    assign elapsed_waddr = wb_active ? wb_idx_reg : id_slot;
    assign elapsed_wdata = (wb_active && !fire) ? count_inc : '0;

    always_ff @(posedge clk)
    begin
        if (period_we)
        begin
            period_mem[id_slot] <= per_ext[PERIOD_BITS-1:0];
        end
        if (elapsed_we)
        begin
            elapsed_mem[elapsed_waddr] <= elapsed_wdata;
        end
        period_rd_reg  <= period_mem[idx_reg];
        elapsed_rd_reg <= elapsed_mem[idx_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        created_next     = created_reg;
        pending_next     = pending_reg;
        scan_pos_next    = scan_pos_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        wb_valid_next    = 1'b0;
        wb_idx_next      = wb_idx_reg;
        res_granted_next = res_granted_reg;
        res_slot_next    = res_slot_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_granted_next = out_granted_reg;
        out_task_next    = out_task_reg;

        // counter writeback comes in the cycle after the read
        if (wb_active && fire)
        begin
            pending_next[wb_idx_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_granted_next = 1'b0;
                    res_slot_next    = '0;
                    state_next       = S_DONE;
                    case (in_action)
                        ACT_TICK:
                        begin
                            idx_next   = '0;
                            state_next = S_TICK;
                        end
                        ACT_CREATE:
                        begin
                            if (period_we)
                            begin
                                created_next[id_slot] = 1'b1;
                                pending_next[id_slot] = 1'b0;
                            end
                        end
                        ACT_WAKE:
                        begin
                            if (id_ok && created_reg[id_slot])
                            begin
                                pending_next[id_slot] = 1'b1;
                            end
                        end
                        ACT_SLEEP:
                        begin
                            if (id_ok && created_reg[id_slot])
                            begin
                                pending_next[id_slot] = 1'b0;
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            idx_next   = scan_pos_reg;
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                wb_valid_next = 1'b1;
                wb_idx_next   = idx_reg;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_TICK_LAST;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            S_TICK_LAST:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    pending_next[idx_reg] = 1'b0;
                    scan_pos_next         = idx_inc;
                    res_granted_next      = 1'b1;
                    res_slot_next         = idx_reg;
                    state_next            = S_DONE;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free or being emptied
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_task_next    = res_granted_reg ? res_slot_ext[3:0] : 4'd0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_slot_ext = 32'(res_slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            created_reg   <= '0;
            pending_reg   <= '0;
            scan_pos_reg  <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            created_reg   <= created_next;
            pending_reg   <= pending_next;
            scan_pos_reg  <= scan_pos_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wb_idx_reg      <= wb_idx_next;
        res_granted_reg <= res_granted_next;
        res_slot_reg    <= res_slot_next;
        out_granted_reg <= out_granted_next;
        out_task_reg    <= out_task_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {4'd0, out_task_reg};
    assign m_axis_tuser[0] = out_granted_reg;

    // a result without a grant carries slot zero
    a_no_grant_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("ungranted result carries a nonzero slot");

    // counter writeback happens only inside a tick pass
    a_wb_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> (state_reg == S_TICK) || (state_reg == S_TICK_LAST))
        else $error("counter writeback outside a tick pass");

    // a grant clears the pending bit of the granted slot
    a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && hit |=> !pending_reg[$past(idx_reg)])
        else $error("granted slot still pending");

    // the request side stays closed while a request is being worked on
    a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule
